/* rtl/ism_pkg.sv */
// Shared types and constants for the interval subscription matcher.
// Holds the table geometry, the controller states and the memory port structs.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ism_pkg;

  // Table geometry.
  localparam int MAX_SUBS    = 1024;
  localparam int NUM_ATTRS   = 16;
  localparam int VALUE_BITS  = 20;
  localparam int SLOT_BITS   = $clog2(MAX_SUBS);
  localparam int ATTR_BITS   = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int TABLE_DEPTH = MAX_SUBS * NUM_ATTRS;
  localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);

  // Port field widths.
  localparam int SUB_ID_W = 10;
  localparam int ATTR_W   = 4;
  localparam int FIELD_W  = 20;
  localparam int COUNT_W  = 11;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [ATTR_BITS-1:0]  attr_t;
  typedef logic [TABLE_BITS-1:0] tidx_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [NUM_ATTRS-1:0]  attr_row_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  // Read addresses and write commands towards the constraint store.
  typedef struct packed {
    slot_t     rd_slot;
    tidx_t     rd_idx;
    slot_t     wr_slot;
    tidx_t     wr_idx;
    logic      row_we;
    attr_row_t row_wdata;
    logic      bound_we;
    value_t    low_wdata;
    value_t    high_wdata;
    logic      mark_we;
    logic      mark_wdata;
  } mem_req_t;

  // Registered read data from the constraint store.
  typedef struct packed {
    attr_row_t row;
    value_t    low;
    value_t    high;
    logic      mark;
  } mem_rsp_t;

  // Flat index of one (slot, attribute) entry in the bounds table.
  function automatic tidx_t table_index(slot_t slot, attr_t att);
    tidx_t idx;
    idx = TABLE_BITS'(slot) * TABLE_BITS'(NUM_ATTRS) + TABLE_BITS'(att);
    return idx;
  endfunction

endpackage

/* rtl/ism_store.sv */
// Constraint store: presence rows per slot, bounds per (slot, attribute), event marks.
// Three single-port-write memories with one registered read each.
// Depends on ism_pkg.
`timescale 1ns / 1ps

module ism_store (
  input  logic              clk,
  input  ism_pkg::mem_req_t req,
  output ism_pkg::mem_rsp_t rsp
);

  ism_pkg::attr_row_t                 row_mem   [ism_pkg::MAX_SUBS];
  logic [2*ism_pkg::VALUE_BITS-1:0]   bound_mem [ism_pkg::TABLE_DEPTH];
  logic                               mark_mem  [ism_pkg::MAX_SUBS];

  // Registered read data, one register per memory.
  ism_pkg::attr_row_t                 row_rd;
  logic [2*ism_pkg::VALUE_BITS-1:0]   bound_rd;
  logic                               mark_rd;

  // Presence rows, one bit per attribute of a slot.
  always_ff @(posedge clk) begin
    if (req.row_we) begin
      row_mem[req.wr_slot] <= req.row_wdata;
    end
    row_rd <= row_mem[req.rd_slot];
  end

  // Interval bounds, low in the upper half of the word.
  always_ff @(posedge clk) begin
    if (req.bound_we) begin
      bound_mem[req.wr_idx] <= {req.low_wdata, req.high_wdata};
    end
    bound_rd <= bound_mem[req.rd_idx];
  end

  // Per-event unmatched marks.
  always_ff @(posedge clk) begin
    if (req.mark_we) begin
      mark_mem[req.wr_slot] <= req.mark_wdata;
    end
    mark_rd <= mark_mem[req.rd_slot];
  end

  // Read data in the field order of the response struct.
  assign rsp = {row_rd, bound_rd, mark_rd};

endmodule

/* rtl/interval_subscription_matcher_top.sv */
// Interval subscription matcher: controller, scan pipeline and result register.
// Instantiates ism_store; depends on ism_pkg.
//
//   channel | direction | handshake            | payload
//   in      | into      | in_valid / in_ready  | mode sub_id attribute low_bound
//           |           |                      | high_bound event_value last
//   out     | out of    | out_valid / out_ready| match_count
//
// After reset a clearing pass over all MAX_SUBS (1024) slots empties the presence
// rows and marks; in_ready stays low throughout.
// An insert beat reads the stored entry, then writes the merged entry back.
// An event beat reads one slot per cycle through the store's single read port,
// then writes back the last slot; the beat flagged last also totals the count in
// the same pass and then loads the result from its final state.
// The result sits in an output register; a stalled out side holds the block in its
// final state until the previous count is taken.
`timescale 1ns / 1ps

module interval_subscription_matcher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [ism_pkg::SUB_ID_W-1:0]  sub_id,
  input  logic [ism_pkg::ATTR_W-1:0]    attribute,
  input  logic [ism_pkg::FIELD_W-1:0]   low_bound,
  input  logic [ism_pkg::FIELD_W-1:0]   high_bound,
  input  logic [ism_pkg::FIELD_W-1:0]   event_value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ism_pkg::COUNT_W-1:0]   match_count
);

  localparam ism_pkg::slot_t LAST_SLOT = ism_pkg::SLOT_BITS'(ism_pkg::MAX_SUBS - 1);

  ism_pkg::state_t    state, state_next;
  ism_pkg::mem_req_t  req;
  ism_pkg::mem_rsp_t  rsp;

  // Held item fields.
  ism_pkg::slot_t     slot_q;
  ism_pkg::attr_t     att_q;
  ism_pkg::value_t    low_q;
  ism_pkg::value_t    high_q;
  ism_pkg::value_t    value_q;
  logic               check_q;
  logic               finish_q;

  // Scan and event state.
  ism_pkg::slot_t     scan_addr;
  logic               p_valid;
  ism_pkg::slot_t     p_slot;
  ism_pkg::attr_row_t seen;
  ism_pkg::count_t    count;

  logic               in_accept;
  logic               slot_ok;
  logic               att_ok;
  ism_pkg::slot_t     in_slot;
  ism_pkg::attr_t     in_att;
  ism_pkg::attr_row_t att_bit;
  logic               stored;
  logic               viol;
  logic               unmarked;
  logic               out_load;

  ism_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Input decode.
  assign in_accept = in_valid && in_ready;
  assign slot_ok   = int'(sub_id) < ism_pkg::MAX_SUBS;
  assign att_ok    = int'(attribute) < ism_pkg::NUM_ATTRS;
  assign in_slot   = sub_id[ism_pkg::SLOT_BITS-1:0];
  assign in_att    = attribute[ism_pkg::ATTR_BITS-1:0];
  assign att_bit   = ism_pkg::attr_row_t'(1) << att_q;

  // Per-slot evaluation of the entry read in the previous cycle.
  assign stored   = rsp.row[att_q];
  assign viol     = check_q && stored && ((rsp.low > value_q) || (rsp.high < value_q));
  assign unmarked = !(rsp.mark || viol || (|(rsp.row & ~seen)));
  assign out_load = (state == ism_pkg::ST_DONE) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ism_pkg::ST_CLEAR: begin
        if (scan_addr == LAST_SLOT) state_next = ism_pkg::ST_IDLE;
      end
      ism_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!mode) begin
            if (slot_ok && att_ok) state_next = ism_pkg::ST_INSERT;
          end else if (att_ok || last) begin
            state_next = ism_pkg::ST_SCAN;
          end
        end
      end
      ism_pkg::ST_INSERT: begin
        state_next = ism_pkg::ST_IDLE;
      end
      ism_pkg::ST_SCAN: begin
        if (scan_addr == LAST_SLOT) state_next = ism_pkg::ST_SCAN_END;
      end
      ism_pkg::ST_SCAN_END: begin
        state_next = finish_q ? ism_pkg::ST_DONE : ism_pkg::ST_IDLE;
      end
      ism_pkg::ST_DONE: begin
        if (out_load) state_next = ism_pkg::ST_IDLE;
      end
      default: begin
        state_next = ism_pkg::ST_CLEAR;
      end
    endcase
  end

  // Handshake output.
  always_comb begin
    in_ready = (state == ism_pkg::ST_IDLE);
  end

  // Store addresses and write commands.
  always_comb begin
    req            = '0;
    req.rd_slot    = scan_addr;
    req.rd_idx     = ism_pkg::table_index(scan_addr, att_q);
    req.wr_slot    = scan_addr;
    req.wr_idx     = ism_pkg::table_index(slot_q, att_q);
    req.low_wdata  = low_q;
    req.high_wdata = high_q;
    case (state)
      ism_pkg::ST_CLEAR: begin
        req.row_we     = 1'b1;
        req.row_wdata  = '0;
        req.mark_we    = 1'b1;
        req.mark_wdata = 1'b0;
      end
      ism_pkg::ST_IDLE: begin
        req.rd_slot = in_slot;
        req.rd_idx  = ism_pkg::table_index(in_slot, in_att);
      end
      ism_pkg::ST_INSERT: begin
        // Intersect with an existing interval, otherwise store as given.
        req.wr_slot   = slot_q;
        req.row_we    = 1'b1;
        req.row_wdata = rsp.row | att_bit;
        req.bound_we  = 1'b1;
        if (stored && (rsp.low > low_q)) req.low_wdata = rsp.low;
        if (stored && (rsp.high < high_q)) req.high_wdata = rsp.high;
      end
      default: begin
        // Scan write back, at the registered copy of the read address.
        if (p_valid) begin
          req.wr_slot    = p_slot;
          req.mark_we    = finish_q || viol;
          req.mark_wdata = !finish_q;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ism_pkg::ST_CLEAR;
      scan_addr <= '0;
      p_valid   <= 1'b0;
      seen      <= '0;
    end else begin
      state   <= state_next;
      p_valid <= (state == ism_pkg::ST_SCAN);
      if ((state == ism_pkg::ST_CLEAR) || (state == ism_pkg::ST_SCAN)) begin
        scan_addr <= (scan_addr == LAST_SLOT) ? '0 : scan_addr + ism_pkg::slot_t'(1);
      end else if (in_accept) begin
        scan_addr <= '0;
      end
      if (in_accept && mode && att_ok) begin
        seen <= seen | (ism_pkg::attr_row_t'(1) << in_att);
      end else if ((state == ism_pkg::ST_SCAN_END) && finish_q) begin
        seen <= '0;
      end
    end
  end

  // Held item fields and scan pipeline slot.
  always_ff @(posedge clk) begin
    p_slot <= scan_addr;
    if (in_accept) begin
      slot_q   <= in_slot;
      att_q    <= in_att;
      low_q    <= low_bound[ism_pkg::VALUE_BITS-1:0];
      high_q   <= high_bound[ism_pkg::VALUE_BITS-1:0];
      value_q  <= event_value[ism_pkg::VALUE_BITS-1:0];
      check_q  <= att_ok;
      finish_q <= last;
    end
  end

  // Running count of slots still matching at the end of the event.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      count <= '0;
    end else if (p_valid && finish_q) begin
      count <= count + ism_pkg::count_t'(unmarked);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      match_count <= count;
    end
  end

endmodule

/* rtl/ism_checker.sv */
// Port-level checks for the interval subscription matcher.
// Bound to interval_subscription_matcher_top; depends on ism_pkg.
`timescale 1ns / 1ps

module ism_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        mode,
  input logic                        last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ism_pkg::COUNT_W-1:0] match_count
);

  // A stalled result beat holds its count.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_count))
    else $error("result beat changed while stalled");

  // The count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(match_count) <= ism_pkg::MAX_SUBS)
    else $error("match count above slot capacity");

  // The clearing pass keeps the input closed straight after reset.
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open during clearing pass");

  // A closing event beat starts a scan, so the input closes behind it and no new result is raised yet.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode && last |=> !in_ready && !$rose(out_valid))
    else $error("input open or result shown right after closing beat");

endmodule

bind interval_subscription_matcher_top ism_checker u_ism_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .last        (last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .match_count (match_count)
);
